### hdl/assert_macros.svh
// Assertion macros used by the top RTL file of the bounded sequential list.
// Synthesis builds see empty bodies; simulation builds see the checks.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// Check a property at every rising clock edge outside reset.
`define ASSERT_RST(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Check a property at every rising clock edge, reset included.
`define ASSERT_ALWAYS(label, clk, prop, msg) \
    label: assert property (@(posedge clk) prop) else $error(msg);

`else

`define ASSERT_RST(label, clk, rst_n, prop, msg)
`define ASSERT_ALWAYS(label, clk, prop, msg)

`endif

`endif

### hdl/bsl_pkg.sv
// Shared types and constants for the bounded sequential list.
// Used by bsl_ctrl, bsl_datapath and bounded_sequential_list_core.
`default_nettype none

package bsl_pkg;

    // Width of one stored word.
    localparam int WORD_W = 32;

    // Operation codes carried in the mode field.
    typedef enum logic [2:0] {
        MODE_CLEAR     = 3'd0,
        MODE_INS_FRONT = 3'd1,
        MODE_INS_BACK  = 3'd2,
        MODE_REM_FRONT = 3'd3,
        MODE_REM_BACK  = 3'd4,
        MODE_SEARCH    = 3'd5
    } mode_t;

    // Status codes returned with every result.
    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_FULL  = 2'd1,
        ST_EMPTY = 2'd2
    } status_t;

    // Controller states.
    typedef enum logic [1:0] {
        S_IDLE,
        S_EXEC,
        S_REDUCE
    } state_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic take;    // capture the incoming mode and value
        logic apply;   // run a non-search operation and load its result
        logic scan;    // compare every lane against the search value
        logic report;  // fold the lane matches into the search result
    } cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic is_search;
    } sts_t;

endpackage

`default_nettype wire

### hdl/bsl_ctrl.sv
// Controller state machine of the bounded sequential list.
// Depends on bsl_pkg for the state, command and status types.
`default_nettype none

module bsl_ctrl
    import bsl_pkg::*;
(
    input  logic   clk,
    input  logic   rst_n,
    input  logic   req_valid,
    output logic   req_stall,
    output logic   rsp_valid,
    input  logic   rsp_stall,
    input  sts_t   sts,
    output cmd_t   cmd
);

    state_t state_reg;
    state_t state_next;
    logic   rsp_valid_reg;
    logic   rsp_valid_next;
    logic   rsp_free;

    // State and result-valid registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    // The result register can take a new value when it is empty or its transfer completes now.
    assign rsp_free = !rsp_valid_reg || !rsp_stall;

    // Next state and commands.
    always_comb
    begin
        state_next     = state_reg;
        cmd            = '0;
        req_stall      = 1'b1;
        rsp_valid_next = rsp_valid_reg && rsp_stall;
        unique case (state_reg)
            S_IDLE:
            begin
                req_stall = 1'b0;
                if (req_valid)
                begin
                    cmd.take   = 1'b1;
                    state_next = S_EXEC;
                end
            end
            S_EXEC:
            begin
                if (rsp_free)
                begin
                    if (sts.is_search)
                    begin
                        cmd.scan   = 1'b1;
                        state_next = S_REDUCE;
                    end
                    else
                    begin
                        cmd.apply      = 1'b1;
                        rsp_valid_next = 1'b1;
                        state_next     = S_IDLE;
                    end
                end
            end
            S_REDUCE:
            begin
                // The result register was freed before the scan step.
                cmd.report     = 1'b1;
                rsp_valid_next = 1'b1;
                state_next     = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    assign rsp_valid = rsp_valid_reg;

endmodule

`default_nettype wire

### hdl/bsl_datapath.sv
// Datapath of the bounded sequential list: word lanes, fill count, search match
// vector and result registers. Depends on bsl_pkg.
`default_nettype none

module bsl_datapath
    import bsl_pkg::*;
#(
    parameter int CAPACITY = 16,
    parameter int CNT_W    = 5
)
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  cmd_t                     cmd,
    output sts_t                     sts,
    input  logic [2:0]               mode,
    input  logic signed [WORD_W-1:0] value,
    output logic [1:0]               status,
    output logic                     found,
    output logic [CNT_W-1:0]         count
);

    mode_t                     mode_reg;
    mode_t                     mode_next;
    logic signed [WORD_W-1:0]  value_reg;
    logic signed [WORD_W-1:0]  value_next;
    logic signed [WORD_W-1:0]  entries_reg  [CAPACITY];
    logic signed [WORD_W-1:0]  entries_next [CAPACITY];
    logic [CNT_W-1:0]          count_reg;
    logic [CNT_W-1:0]          count_next;
    logic [CAPACITY-1:0]       match_reg;
    logic [CAPACITY-1:0]       match_next;
    status_t                   status_reg;
    status_t                   status_next;
    logic                      found_reg;
    logic                      found_next;
    logic [CNT_W-1:0]          rsp_count_reg;
    logic [CNT_W-1:0]          rsp_count_next;
    logic                      is_full;
    logic                      is_empty;

    // Fill count is control state and resets to zero.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
        end
        else
        begin
            count_reg <= count_next;
        end
    end

    // Payload registers carry no reset.
    always_ff @(posedge clk)
    begin
        mode_reg      <= mode_next;
        value_reg     <= value_next;
        entries_reg   <= entries_next;
        match_reg     <= match_next;
        status_reg    <= status_next;
        found_reg     <= found_next;
        rsp_count_reg <= rsp_count_next;
    end

    assign is_full  = (count_reg == CNT_W'(CAPACITY));
    assign is_empty = (count_reg == '0);

    // Operation logic over all lanes in parallel.
    always_comb
    begin
        mode_next      = mode_reg;
        value_next     = value_reg;
        entries_next   = entries_reg;
        count_next     = count_reg;
        match_next     = match_reg;
        status_next    = status_reg;
        found_next     = found_reg;
        rsp_count_next = rsp_count_reg;

        // Capture the command of the accepted transfer.
        if (cmd.take)
        begin
            mode_next  = mode_t'(mode);
            value_next = value;
        end

        // Run one non-search operation and build its result.
        if (cmd.apply)
        begin
            status_next = ST_OK;
            found_next  = 1'b0;
            unique case (mode_reg)
                MODE_CLEAR:
                begin
                    count_next = '0;
                end
                MODE_INS_FRONT:
                begin
                    if (is_full)
                    begin
                        status_next = ST_FULL;
                    end
                    else
                    begin
                        entries_next[0] = value_reg;
                        for (int i = 1; i < CAPACITY; i++)
                        begin
                            entries_next[i] = entries_reg[i-1];
                        end
                        count_next = count_reg + CNT_W'(1);
                    end
                end
                MODE_INS_BACK:
                begin
                    if (is_full)
                    begin
                        status_next = ST_FULL;
                    end
                    else
                    begin
                        for (int i = 0; i < CAPACITY; i++)
                        begin
                            if (CNT_W'(i) == count_reg)
                            begin
                                entries_next[i] = value_reg;
                            end
                        end
                        count_next = count_reg + CNT_W'(1);
                    end
                end
                MODE_REM_FRONT:
                begin
                    if (is_empty)
                    begin
                        status_next = ST_EMPTY;
                    end
                    else
                    begin
                        for (int i = 0; i < CAPACITY - 1; i++)
                        begin
                            entries_next[i] = entries_reg[i+1];
                        end
                        count_next = count_reg - CNT_W'(1);
                    end
                end
                MODE_REM_BACK:
                begin
                    if (is_empty)
                    begin
                        status_next = ST_EMPTY;
                    end
                    else
                    begin
                        count_next = count_reg - CNT_W'(1);
                    end
                end
                default:
                begin
                    // Search never reaches this path; undefined codes change nothing.
                end
            endcase
            rsp_count_next = count_next;
        end

        // Compare each occupied lane against the search value.
        if (cmd.scan)
        begin
            for (int i = 0; i < CAPACITY; i++)
            begin
                match_next[i] = (entries_reg[i] == value_reg) && (CNT_W'(i) < count_reg);
            end
        end

        // Fold the lane matches into the search result.
        if (cmd.report)
        begin
            status_next    = ST_OK;
            found_next     = |match_reg;
            rsp_count_next = count_reg;
        end
    end

    assign sts.is_search = (mode_reg == MODE_SEARCH);
    assign status        = status_reg;
    assign found         = found_reg;
    assign count         = rsp_count_reg;

endmodule

`default_nettype wire

### hdl/bounded_sequential_list_core.sv
// Bounded ordered list of signed 32-bit words with front and back insert and remove,
// clear and membership search; each accepted item returns one result holding a status,
// a found flag and the count after the operation. One item is in work at a time: an
// item passes a command register stage and an execute step that waits for a free output
// register; a search adds a reduce step, since the lane compares are registered before
// they are reduced to the found flag. A result waiting in the output register does not
// block the transfer of the next item into the command register. There is no clearing
// pass after reset. Depends on bsl_pkg, bsl_ctrl, bsl_datapath, assert_macros.svh.
`default_nettype none
`include "assert_macros.svh"

module bounded_sequential_list_core
    import bsl_pkg::*;
#(
    parameter int CAPACITY = 16
)
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     req_valid,
    output logic                     req_stall,
    input  logic [2:0]               mode,
    input  logic signed [WORD_W-1:0] value,
    output logic                     rsp_valid,
    input  logic                     rsp_stall,
    output logic [1:0]               status,
    output logic                     found,
    output logic [$clog2(CAPACITY+1)-1:0] count
);

    localparam int CNT_W = $clog2(CAPACITY + 1);

    cmd_t cmd;
    sts_t sts;

    // Controller.
    bsl_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_stall (req_stall),
        .rsp_valid (rsp_valid),
        .rsp_stall (rsp_stall),
        .sts       (sts),
        .cmd       (cmd)
    );

    // Datapath.
    bsl_datapath #(
        .CAPACITY (CAPACITY),
        .CNT_W    (CNT_W)
    ) u_datapath (
        .clk    (clk),
        .rst_n  (rst_n),
        .cmd    (cmd),
        .sts    (sts),
        .mode   (mode),
        .value  (value),
        .status (status),
        .found  (found),
        .count  (count)
    );

    // Only one item is in work: a transfer is always followed by a stalled cycle.
    `ASSERT_RST(a_single_item, clk, rst_n, (req_valid && !req_stall) |=> req_stall, "second item accepted while one is in work")

    // A new result appears only right after the input side was busy.
    `ASSERT_RST(a_result_after_work, clk, rst_n, $rose(rsp_valid) |-> $past(req_stall), "result without an item in work")

    // A reported count never exceeds the capacity.
    `ASSERT_RST(a_count_bound, clk, rst_n, rsp_valid |-> (count <= CNT_W'(CAPACITY)), "reported count above capacity")

    // The result channel is idle while reset is applied.
    `ASSERT_ALWAYS(a_reset_idle, clk, !rst_n |-> !rsp_valid, "result valid during reset")

endmodule

`default_nettype wire

### bench/tb_bounded_sequential_list_core.sv
// Self-checking testbench for bounded_sequential_list_core: directed and random list operations.
// A shadow copy of the list predicts status, found flag and count for every transfer.
// Depends on bsl_pkg and the RTL of bounded_sequential_list_core.
`timescale 1ns / 1ps

module tb_bounded_sequential_list_core;
    import bsl_pkg::*;

    localparam int LIST_DEPTH   = 16;
    localparam int CNT_W        = $clog2(LIST_DEPTH + 1);
    localparam int TOTAL_ITEMS  = 1650;
    localparam int QUIET_ITEMS  = 200;
    localparam int TAIL_CYCLES  = 10;

    // Mode codes that the block must treat as no-ops.
    localparam logic [2:0] MODE_SPARE_A = 3'd6;
    localparam logic [2:0] MODE_SPARE_B = 3'd7;

    // Stimulus bias of one random phase.
    localparam int BIAS_GROW   = 0;
    localparam int BIAS_SHRINK = 1;
    localparam int BIAS_MIX    = 2;

    typedef struct packed {
        status_t          st;
        logic             fnd;
        logic [CNT_W-1:0] cnt;
    } list_result_t;

    // Shadow list plus the queue of results still owed by the block.
    class list_scoreboard;
        logic [WORD_W-1:0] words [LIST_DEPTH];
        int unsigned       fill;
        list_result_t      expected_q [$];
        int unsigned       errors;

        function new();
            fill   = 0;
            errors = 0;
        endfunction

        function int unsigned pending();
            return expected_q.size();
        endfunction

        // Applies one accepted operation to the shadow list and queues its result.
        function void note_request(logic [2:0] op, logic [WORD_W-1:0] word);
            list_result_t res;
            int           i;
            res.st  = ST_OK;
            res.fnd = 1'b0;
            case (op)
                MODE_CLEAR:
                begin
                    fill = 0;
                end
                MODE_INS_FRONT:
                begin
                    if (fill >= LIST_DEPTH)
                        res.st = ST_FULL;
                    else
                    begin
                        for (i = fill; i > 0; i--)
                            words[i] = words[i-1];
                        words[0] = word;
                        fill++;
                    end
                end
                MODE_INS_BACK:
                begin
                    if (fill >= LIST_DEPTH)
                        res.st = ST_FULL;
                    else
                    begin
                        words[fill] = word;
                        fill++;
                    end
                end
                MODE_REM_FRONT:
                begin
                    if (fill == 0)
                        res.st = ST_EMPTY;
                    else
                    begin
                        for (i = 0; i + 1 < fill; i++)
                            words[i] = words[i+1];
                        fill--;
                    end
                end
                MODE_REM_BACK:
                begin
                    if (fill == 0)
                        res.st = ST_EMPTY;
                    else
                        fill--;
                end
                MODE_SEARCH:
                begin
                    for (i = 0; i < fill; i++)
                        if (words[i] == word)
                            res.fnd = 1'b1;
                end
                default:
                begin
                end
            endcase
            res.cnt = CNT_W'(fill);
            expected_q.push_back(res);
        endfunction

        function void report(string field, int unsigned want, int unsigned got);
            errors++;
            $display("%0t: %s mismatch, expected %0d, actual %0d", $time, field, want, got);
        endfunction

        // Compares one result transfer with the oldest expectation.
        function void check_response(logic [1:0] st, logic fnd, logic [CNT_W-1:0] cnt);
            list_result_t want;
            if (expected_q.size() == 0)
            begin
                errors++;
                $display("%0t: unexpected result, expected none,", $time,
                         " actual status %0d found %0d count %0d", st, fnd, cnt);
                return;
            end
            want = expected_q.pop_front();
            if (st !== want.st)
                report("status", want.st, st);
            if (fnd !== want.fnd)
                report("found", want.fnd, fnd);
            if (cnt !== want.cnt)
                report("count", want.cnt, cnt);
        endfunction
    endclass

    logic                     clk;
    logic                     rst_n;
    logic                     req_valid;
    logic                     req_stall;
    logic [2:0]               mode;
    logic signed [WORD_W-1:0] value;
    logic                     rsp_valid;
    logic                     rsp_stall;
    logic [1:0]               status;
    logic                     found;
    logic [CNT_W-1:0]         count;

    list_scoreboard sb;
    bit             send_idle_on;
    bit             recv_idle_on;
    int unsigned    items_sent;

    bounded_sequential_list_core #(
        .CAPACITY (LIST_DEPTH)
    ) DUT (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_stall (req_stall),
        .mode      (mode),
        .value     (value),
        .rsp_valid (rsp_valid),
        .rsp_stall (rsp_stall),
        .status    (status),
        .found     (found),
        .count     (count)
    );

    // Free-running clock.
    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Watch both channels at the rising edge and feed the scoreboard.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (req_valid && !req_stall)
                sb.note_request(mode, value);
            if (rsp_valid && !rsp_stall)
                sb.check_response(status, found, count);
        end
    end

    // Result side: random stall bursts while enabled.
    initial
    begin
        rsp_stall = 1'b0;
        forever
        begin
            @(negedge clk);
            if (recv_idle_on && $urandom_range(0, 5) == 0)
            begin
                rsp_stall <= 1'b1;
                repeat ($urandom_range(1, 18)) @(negedge clk);
                rsp_stall <= 1'b0;
            end
        end
    end

    // Drives one transfer, with an optional idle burst first; returns at a falling edge.
    task automatic send_item(input logic [2:0] op, input logic [WORD_W-1:0] word);
        if (send_idle_on && $urandom_range(0, 3) == 0)
        begin
            req_valid <= 1'b0;
            repeat ($urandom_range(1, 18)) @(negedge clk);
        end
        req_valid <= 1'b1;
        mode      <= op;
        value     <= word;
        @(posedge clk);
        while (req_stall)
            @(posedge clk);
        items_sent++;
        @(negedge clk);
    endtask

    // Holds the request side idle until every owed result has come back.
    task automatic hold_until_drained();
        req_valid <= 1'b0;
        while (sb.pending() != 0)
            @(posedge clk);
        @(negedge clk);
    endtask

    function automatic logic [2:0] choose_mode(int bias);
        int r;
        bit grow;
        r = $urandom_range(0, 99);
        if (r < 2)
            return (bias == BIAS_MIX) ? MODE_CLEAR : MODE_SEARCH;
        if (r < 4)
            return $urandom_range(0, 1) ? MODE_SPARE_A : MODE_SPARE_B;
        if (r < 30)
            return MODE_SEARCH;
        if (bias == BIAS_GROW)
            grow = (r < 85);
        else if (bias == BIAS_SHRINK)
            grow = (r < 45);
        else
            grow = (r < 65);
        if (grow)
            return $urandom_range(0, 1) ? MODE_INS_FRONT : MODE_INS_BACK;
        return $urandom_range(0, 1) ? MODE_REM_FRONT : MODE_REM_BACK;
    endfunction

    // Searches mostly look for stored words or near misses; other words are
    // random, drawn from a small pool so duplicates occur, or extremes.
    function automatic logic [WORD_W-1:0] choose_value(logic [2:0] op);
        int r;
        logic [WORD_W-1:0] w;
        r = $urandom_range(0, 99);
        if (op == MODE_SEARCH && sb.fill != 0 && r < 55)
        begin
            w = sb.words[$urandom_range(0, sb.fill - 1)];
            if (r < 10)
                w = w ^ (32'h1 << $urandom_range(0, 31));
            return w;
        end
        if (r < 55)
            return $urandom;
        if (r < 80)
            return $urandom_range(0, 7);
        case (r % 4)
            0:       w = 32'h8000_0000;
            1:       w = 32'h7FFF_FFFF;
            2:       w = 32'h0000_0000;
            default: w = 32'hFFFF_FFFF;
        endcase
        return w;
    endfunction

    task automatic run_phase(input int bias, input int len);
        logic [2:0] op;
        repeat (len)
        begin
            op = choose_mode(bias);
            send_item(op, choose_value(op));
        end
    endtask

    // Empty-list cases, no-op modes, a fill to capacity with extreme words,
    // inserts on a full list, searches and removes.
    task automatic run_directed();
        logic [WORD_W-1:0] word;
        int k;
        send_item(MODE_CLEAR, 32'h0);
        send_item(MODE_REM_FRONT, 32'h1);
        send_item(MODE_REM_BACK, 32'h2);
        send_item(MODE_SEARCH, 32'h0);
        send_item(MODE_SPARE_A, 32'hFFFF_FFFF);
        send_item(MODE_SPARE_B, 32'h8000_0000);
        for (k = 0; k < LIST_DEPTH; k++)
        begin
            case (k)
                0:       word = 32'h7FFF_FFFF;
                1:       word = 32'h8000_0000;
                2:       word = 32'h0000_0000;
                3:       word = 32'hFFFF_FFFF;
                default: word = 32'h5A5A_0000 + k;
            endcase
            send_item((k % 2) ? MODE_INS_BACK : MODE_INS_FRONT, word);
        end
        send_item(MODE_INS_FRONT, 32'hAAAA_AAAA);
        send_item(MODE_INS_BACK, 32'h5555_5555);
        send_item(MODE_SEARCH, 32'h8000_0000);
        send_item(MODE_SEARCH, 32'h1234_5678);
        send_item(MODE_REM_FRONT, 32'h0);
        send_item(MODE_REM_BACK, 32'h0);
        send_item(MODE_CLEAR, 32'h0);
    endtask

    // Main sequence: reset, directed part, random phases, drain and verdict.
    initial
    begin
        bit midway_done;
        sb           = new();
        rst_n        = 1'b0;
        req_valid    = 1'b0;
        mode         = 3'd0;
        value        = '0;
        items_sent   = 0;
        midway_done  = 1'b0;
        send_idle_on = 1'b0;
        recv_idle_on = 1'b0;
        repeat (11) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        send_idle_on = 1'b1;
        recv_idle_on <= 1'b1;
        run_directed();
        hold_until_drained();

        while (items_sent < TOTAL_ITEMS)
        begin
            if (items_sent >= TOTAL_ITEMS - QUIET_ITEMS)
            begin
                send_idle_on = 1'b0;
                recv_idle_on <= 1'b0;
            end
            else
            begin
                send_idle_on = ($urandom_range(0, 9) < 7);
                recv_idle_on <= ($urandom_range(0, 9) < 7);
            end
            run_phase($urandom_range(BIAS_GROW, BIAS_MIX), $urandom_range(4, 28));
            if (!midway_done && items_sent > TOTAL_ITEMS / 2)
            begin
                midway_done = 1'b1;
                hold_until_drained();
            end
        end

        hold_until_drained();
        repeat (TAIL_CYCLES) @(posedge clk);
        if (sb.errors == 0 && sb.pending() == 0)
            $display("bounded_sequential_list_core regression: pass");
        else
            $display("bounded_sequential_list_core regression: fail");
        $finish;
    end

    // Watchdog for a hung handshake.
    initial
    begin
        #5_000_000;
        $display("bounded_sequential_list_core regression: fail");
        $finish;
    end

endmodule

### bounded_sequential_list_core.f
+incdir+hdl
hdl/bsl_pkg.sv
hdl/bsl_ctrl.sv
hdl/bsl_datapath.sv
hdl/bounded_sequential_list_core.sv
bench/tb_bounded_sequential_list_core.sv
